FILE: rtl/ftp_rp_pkg.sv
// ----------------------------------------------------------------------------
// ftp_rp_pkg
// Types, character constants, code table and character update for the FTP
// reply parser.
// ----------------------------------------------------------------------------
package ftp_rp_pkg;

   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_HYPHEN = 8'h2D;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;

   localparam int NUM_CODES = 48;

   localparam logic [9:0] KNOWN_CODES [NUM_CODES] = '{
      10'd110, 10'd120, 10'd125, 10'd150,
      10'd200, 10'd202, 10'd211, 10'd212, 10'd213, 10'd214, 10'd215, 10'd220,
      10'd221, 10'd225, 10'd226, 10'd227,
      10'd228, 10'd229, 10'd230, 10'd231, 10'd232, 10'd234, 10'd250, 10'd257,
      10'd331, 10'd332, 10'd350,
      10'd421, 10'd425, 10'd426, 10'd430, 10'd434, 10'd450, 10'd451, 10'd452,
      10'd501, 10'd502, 10'd503, 10'd504, 10'd530, 10'd532, 10'd550, 10'd551,
      10'd552, 10'd553,
      10'd631, 10'd632, 10'd633
   };

   typedef enum logic [1:0] {
      ST_COMPLETE  = 2'd0,
      ST_SHORT     = 2'd1,
      ST_BAD_SEP   = 2'd2,
      ST_TRUNCATED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      SEP_NONE   = 2'd0,
      SEP_SPACE  = 2'd1,
      SEP_HYPHEN = 2'd2,
      SEP_OTHER  = 2'd3
   } sep_type;

   typedef enum logic [2:0] {
      PH_FIRST = 3'b001,
      PH_CONT  = 3'b010,
      PH_DRAIN = 3'b100
   } phase_type;

   localparam logic [2:0] COL_CODE = 3'd3;
   localparam logic [2:0] COL_MAX  = 3'd4;

   typedef struct packed {
      logic [2:0]      column;
      logic [2:0][7:0] chars;
      logic            digits_ok;
      sep_type         sep_kind;
      logic            prefix_match;
   } line_type;

   localparam line_type LINE_CLEAR = '{
      column: 3'd0, chars: '0, digits_ok: 1'b1, sep_kind: SEP_NONE,
      prefix_match: 1'b1
   };

   function automatic logic code_is_known(input logic [9:0] code);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < NUM_CODES; i++) begin
         if (KNOWN_CODES[i] == code) begin
            hit = 1'b1;
         end
      end
      return hit;
   endfunction

   function automatic line_type feed_char(input line_type s, input logic first,
                                          input logic [7:0] c);
      line_type r;
      r = s;
      if (first) begin
         if (s.column < COL_CODE) begin
            r.chars[s.column[1:0]] = c;
            if (c < CHAR_ZERO || c > CHAR_NINE) begin
               r.digits_ok = 1'b0;
            end
         end else if (s.column == COL_CODE) begin
            if (c == CHAR_SPACE) begin
               r.sep_kind = SEP_SPACE;
            end else if (c == CHAR_HYPHEN) begin
               r.sep_kind = SEP_HYPHEN;
            end else begin
               r.sep_kind = SEP_OTHER;
            end
         end
      end else if (s.column < COL_CODE && c != s.chars[s.column[1:0]]) begin
         r.prefix_match = 1'b0;
      end
      if (s.column < COL_MAX) begin
         r.column = s.column + 3'd1;
      end
      return r;
   endfunction

endpackage

FILE: rtl/ftp_reply_parser_top.sv
// ----------------------------------------------------------------------------
// ftp_reply_parser_top
// Byte-wide FTP reply parser: finds the reply code, single or multi-line
// form and line count, and reports one result per reply.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake             | payload
//  req      | in  | req_tvalid/req_tready | tdata: byte_in; tlast: buffer_end
//  rsp      | out | rsp_tvalid/rsp_tready | tdata: status, reply_code,
//           |     |                       |   code_known, is_multiline,
//           |     |                       |   line_total
//
//  One request per cycle; the parse state updates in the accepting cycle and
//  a result shows in the output register on the next cycle.
//  Throughput is set by the single result register: requests stall only while
//  a result waits and rsp_tready is low.
//  Synchronous reset returns the parser to the start of a reply.
// ----------------------------------------------------------------------------
module ftp_reply_parser_top #(
   parameter int LINE_COUNT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_in
   input  logic        req_tlast,   // buffer_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [1:0] status, [11:2] reply_code,
                                    // [12] code_known, [13] is_multiline,
                                    // [29:14] line_total, [31:30] zero
);
   import ftp_rp_pkg::*;

   localparam int CntW = (LINE_COUNT_BITS < 16) ? LINE_COUNT_BITS : 16;
   localparam logic [CntW-1:0] CntMax = '1;

   phase_type        phase_ff, phase_in;
   line_type         line_ff, line_in;
   logic             cr_ff, cr_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [31:0]      rsp_data_ff, rsp_data_in;

   logic             accept;
   logic             emit;
   status_type       res_status;
   logic [9:0]       res_code;
   logic             res_ml;
   logic [CntW-1:0]  res_lines;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      line_type        ln;
      logic            end_now;
      logic            first;
      logic [9:0]      code;
      logic [CntW-1:0] cnt_next;

      phase_in   = phase_ff;
      line_in    = line_ff;
      cr_in      = cr_ff;
      cnt_in     = cnt_ff;
      emit       = 1'b0;
      res_status = ST_COMPLETE;
      res_code   = '0;
      res_ml     = 1'b0;
      res_lines  = '0;
      ln         = line_ff;
      end_now    = 1'b0;
      first      = (phase_ff == PH_FIRST);
      code       = '0;
      cnt_next   = cnt_ff;

      if (accept) begin
         if (phase_ff == PH_DRAIN) begin
            if (req_tlast) begin
               phase_in = PH_FIRST;
               line_in  = LINE_CLEAR;
               cr_in    = 1'b0;
               cnt_in   = '0;
            end
         end else begin
            if (cr_ff) begin
               cr_in = 1'b0;
               if (req_tdata == CHAR_LF) begin
                  end_now = 1'b1;
               end else begin
                  ln = feed_char(ln, first, CHAR_CR);
               end
            end
            if (!end_now) begin
               if (req_tdata == CHAR_CR && !req_tlast) begin
                  cr_in = 1'b1;
               end else begin
                  ln      = feed_char(ln, first, req_tdata);
                  end_now = req_tlast;
               end
            end
            line_in = ln;

            if (end_now) begin
               if (ln.digits_ok && ln.column >= COL_CODE) begin
                  code = 10'(ln.chars[0][3:0]) * 10'd100
                       + 10'(ln.chars[1][3:0]) * 10'd10
                       + 10'(ln.chars[2][3:0]);
               end
               if (first) begin
                  if (ln.column < COL_CODE || !ln.digits_ok) begin
                     emit       = 1'b1;
                     res_status = ST_SHORT;
                  end else if (ln.sep_kind == SEP_SPACE) begin
                     emit      = 1'b1;
                     res_code  = code;
                     res_lines = CntW'(1);
                  end else if (ln.sep_kind == SEP_HYPHEN) begin
                     if (req_tlast) begin
                        emit       = 1'b1;
                        res_status = ST_TRUNCATED;
                        res_code   = code;
                        res_ml     = 1'b1;
                        res_lines  = CntW'(1);
                     end else begin
                        phase_in             = PH_CONT;
                        cnt_in               = CntW'(1);
                        line_in.column       = '0;
                        line_in.prefix_match = 1'b1;
                     end
                  end else begin
                     emit       = 1'b1;
                     res_status = ST_BAD_SEP;
                     res_code   = code;
                  end
               end else begin
                  if (cnt_ff != CntMax) begin
                     cnt_next = cnt_ff + CntW'(1);
                  end
                  if (ln.column >= COL_CODE && ln.prefix_match) begin
                     emit      = 1'b1;
                     res_code  = code;
                     res_ml    = 1'b1;
                     res_lines = cnt_next;
                  end else if (req_tlast) begin
                     emit       = 1'b1;
                     res_status = ST_TRUNCATED;
                     res_code   = code;
                     res_ml     = 1'b1;
                     res_lines  = cnt_next;
                  end else begin
                     cnt_in               = cnt_next;
                     line_in.column       = '0;
                     line_in.prefix_match = 1'b1;
                  end
               end

               if (emit) begin
                  phase_in = req_tlast ? PH_FIRST : PH_DRAIN;
                  line_in  = LINE_CLEAR;
                  cr_in    = 1'b0;
                  cnt_in   = '0;
               end
            end
         end
      end
   end

   always_comb begin
      logic known;
      known        = (res_status != ST_SHORT) && code_is_known(res_code);
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {2'b00, 16'(res_lines), res_ml, known, res_code, res_status};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_FIRST;
         line_ff      <= LINE_CLEAR;
         cr_ff        <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         line_ff      <= line_in;
         cr_ff        <= cr_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

FILE: bench/ftp_reply_parser_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ftp_reply_parser_top_tb
// Streams reply buffers byte by byte into the parser and checks each result
// against a cycle-free software copy of the parse. The buffers are directed
// corner cases, then random well-formed single and multi-line replies mixed
// with noise. Both sides idle at random.
// ----------------------------------------------------------------------------
module ftp_reply_parser_top_tb;
   import ftp_rp_pkg::*;

   localparam int LINE_LIMIT = 65535;

   typedef struct {
      logic [7:0] data;
      logic       last;
      logic       hold;
   } req_item_type;

   typedef struct packed {
      status_type status;
      logic [9:0] code;
      logic       known;
      logic       ml;
      logic [15:0] lines;
   } reply_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] byte_in
   logic        req_tlast = 1'b0;    // buffer_end
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;           // [1:0] status, [11:2] reply_code,
                                     // [12] code_known, [13] is_multiline,
                                     // [29:14] line_total

   ftp_reply_parser_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   req_item_type     pending[$];
   reply_result_type replies_expected[$];
   req_item_type     nxt;
   reply_result_type want;

   // parser shadow state
   phase_type  phase;
   int         col;
   logic [7:0] code_ch [3];
   logic       dig_ok;
   sep_type    sep;
   logic       pfx_ok;
   logic       cr_wait;
   int         line_cnt;

   int errors = 0;
   int n_checked = 0;
   int n_buffers = 0;
   int n_bytes = 0;
   int n_multi = 0;
   int n_known = 0;
   int n_status [4] = '{0, 0, 0, 0};
   int idle_left = 0;
   int stall_left = 0;
   logic [15:0] cycle_no = '0;

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   always @(posedge clock) cycle_no <= cycle_no + 16'd1;

   // no idling in the closing stretch, and none in one of four windows
   function automatic logic calm_now();
      return (pending.size() < 100) || (cycle_no[8:7] == 2'b00);
   endfunction

   // ---------------- shadow parser ----------------
   task automatic new_reply();
      phase    = PH_FIRST;
      col      = 0;
      code_ch  = '{8'h00, 8'h00, 8'h00};
      dig_ok   = 1'b1;
      sep      = SEP_NONE;
      pfx_ok   = 1'b1;
      cr_wait  = 1'b0;
      line_cnt = 0;
   endtask

   task automatic take_char(input logic [7:0] c);
      if (phase == PH_FIRST) begin
         if (col < 3) begin
            code_ch[col] = c;
            if (c < CHAR_ZERO || c > CHAR_NINE) dig_ok = 1'b0;
         end else if (col == 3) begin
            if (c == CHAR_SPACE) sep = SEP_SPACE;
            else if (c == CHAR_HYPHEN) sep = SEP_HYPHEN;
            else sep = SEP_OTHER;
         end
      end else if (col < 3 && c != code_ch[col]) begin
         pfx_ok = 1'b0;
      end
      if (col < 4) col++;
   endtask

   task automatic post_result(input status_type st, input int code, input logic ml,
                              input int lines, input logic last);
      reply_result_type r;
      r.status = st;
      r.code   = code[9:0];
      r.ml     = ml;
      r.lines  = lines[15:0];
      r.known  = 1'b0;
      if (st != ST_SHORT) begin
         for (int i = 0; i < NUM_CODES; i++) begin
            if (KNOWN_CODES[i] == code[9:0]) r.known = 1'b1;
         end
      end
      replies_expected.insert(replies_expected.size(), r);
      new_reply();
      if (!last) phase = PH_DRAIN;
   endtask

   task automatic close_line(input logic last);
      int code;
      code = 0;
      if (dig_ok && col >= 3)
         code = int'(code_ch[0] - CHAR_ZERO) * 100 + int'(code_ch[1] - CHAR_ZERO) * 10
                + int'(code_ch[2] - CHAR_ZERO);
      if (phase == PH_FIRST) begin
         if (col < 3 || !dig_ok) post_result(ST_SHORT, 0, 1'b0, 0, last);
         else if (sep == SEP_SPACE) post_result(ST_COMPLETE, code, 1'b0, 1, last);
         else if (sep == SEP_HYPHEN) begin
            line_cnt = 1;
            if (last) post_result(ST_TRUNCATED, code, 1'b1, line_cnt, last);
            else begin
               phase  = PH_CONT;
               col    = 0;
               pfx_ok = 1'b1;
            end
         end else post_result(ST_BAD_SEP, code, 1'b0, 0, last);
      end else begin
         if (line_cnt < LINE_LIMIT) line_cnt++;
         if (col >= 3 && pfx_ok) post_result(ST_COMPLETE, code, 1'b1, line_cnt, last);
         else if (last) post_result(ST_TRUNCATED, code, 1'b1, line_cnt, last);
         else begin
            col    = 0;
            pfx_ok = 1'b1;
         end
      end
   endtask

   task automatic track_byte(input logic [7:0] b, input logic last);
      if (phase == PH_DRAIN) begin
         if (last) new_reply();
      end else begin
         if (cr_wait) begin
            cr_wait = 1'b0;
            if (b == CHAR_LF) begin
               close_line(last);
               return;
            end
            take_char(CHAR_CR);
         end
         if (b == CHAR_CR && !last) cr_wait = 1'b1;
         else begin
            take_char(b);
            if (last) close_line(1'b1);
         end
      end
   endtask

   // ---------------- stimulus helpers ----------------
   task automatic push_req(input logic [7:0] b, input logic last);
      req_item_type it;
      it.data = b;
      it.last = last;
      it.hold = 1'b0;
      pending.insert(pending.size(), it);
      if (last) n_buffers++;
   endtask

   task automatic push_str(input string s, input logic last);
      for (int i = 0; i < s.len(); i++) push_req(s[i], last && (i == s.len() - 1));
   endtask

   task automatic push_crlf(input logic last);
      push_req(CHAR_CR, 1'b0);
      push_req(CHAR_LF, last);
   endtask

   task automatic push_digits(input int code);
      push_req(8'(CHAR_ZERO + code / 100), 1'b0);
      push_req(8'(CHAR_ZERO + (code / 10) % 10), 1'b0);
      push_req(8'(CHAR_ZERO + code % 10), 1'b0);
   endtask

   task automatic push_text(input int n);
      int k;
      repeat (n) begin
         k = $urandom_range(0, 9);
         if (k < 7) push_req(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
         else if (k == 7) push_req(CHAR_CR, 1'b0);
         else push_req(8'($urandom_range(0, 255)), 1'b0);
      end
   endtask

   function automatic logic [7:0] noise_byte();
      case ($urandom_range(0, 5))
         0: return 8'($urandom_range(0, 255));
         1: return 8'($urandom_range(CHAR_ZERO, CHAR_NINE));
         2: return CHAR_CR;
         3: return CHAR_LF;
         4: return $urandom_range(0, 1) ? CHAR_SPACE : CHAR_HYPHEN;
         default: return 8'($urandom_range(8'h20, 8'h7E));
      endcase
   endfunction

   // ---------------- request driver ----------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         new_reply();
      end else begin
         if (req_tvalid && req_tready) begin
            track_byte(req_tdata, req_tlast);
            n_bytes++;
         end
         if (!req_tvalid || req_tready) begin
            if (idle_left > 0) begin
               idle_left--;
               req_tvalid <= 1'b0;
            end else if (pending.size() > 0 &&
                         !(pending[0].hold && replies_expected.size() != 0)) begin
               nxt = pending.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= nxt.data;
               req_tlast  <= nxt.last;
               if (!calm_now() && $urandom_range(0, 9) == 0) idle_left = $urandom_range(1, 7);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------- result monitor ----------------
   task automatic check_field(input string name, input int unsigned exp_v,
                              input int unsigned act_v);
      if (exp_v != act_v) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (replies_expected.size() == 0) begin
               errors++;
               $display("%0t: unexpected result, expected none, actual %h", $time, rsp_tdata);
            end else begin
               want = replies_expected.pop_front();
               check_field("status", want.status, rsp_tdata[1:0]);
               check_field("reply_code", want.code, rsp_tdata[11:2]);
               check_field("code_known", want.known, rsp_tdata[12]);
               check_field("is_multiline", want.ml, rsp_tdata[13]);
               check_field("line_total", want.lines, rsp_tdata[29:14]);
               check_field("pad", 0, rsp_tdata[31:30]);
               n_checked++;
               n_status[want.status]++;
               if (want.ml) n_multi++;
               if (want.known) n_known++;
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (!calm_now() && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 7);
         end
      end
   end

   // ---------------- stimulus and end of run ----------------
   initial begin
      int code;
      int first_idx;
      logic multi;

      // single line then a drained byte; one-byte short line
      push_str("220 ", 1'b0);
      push_crlf(1'b0);
      push_req(8'h00, 1'b1);
      push_req(8'hFF, 1'b1);
      // code with no separator
      push_str("999", 1'b1);
      // multi-line cut off where the LF is the final byte
      push_str("633-", 1'b0);
      push_crlf(1'b1);
      // closing line ended by a CR on the final byte
      push_str("421-", 1'b0);
      push_crlf(1'b0);
      push_str("421", 1'b0);
      push_req(CHAR_CR, 1'b1);

      while (pending.size() < 950) begin
         first_idx = pending.size();
         if ($urandom_range(0, 9) < 7) begin
            if ($urandom_range(0, 2) != 0) code = KNOWN_CODES[$urandom_range(0, NUM_CODES - 1)];
            else code = $urandom_range(0, 999);
            multi = $urandom_range(0, 1);
            push_digits(code);
            push_req(multi ? CHAR_HYPHEN : CHAR_SPACE, 1'b0);
            push_text($urandom_range(0, 6));
            if (multi) begin
               repeat ($urandom_range(0, 4)) begin
                  push_crlf(1'b0);
                  case ($urandom_range(0, 2))
                     0: push_text($urandom_range(0, 6));
                     1: begin
                        push_req(8'(CHAR_ZERO + code / 100), 1'b0);
                        push_req(8'(CHAR_ZERO + (code / 10) % 10), 1'b0);
                        push_req(8'(CHAR_ZERO + (code + 1) % 10), 1'b0);
                        push_text($urandom_range(0, 4));
                     end
                     default: ;
                  endcase
               end
               if ($urandom_range(0, 5) != 0) begin
                  push_crlf(1'b0);
                  push_digits(code);
                  push_req(CHAR_SPACE, 1'b0);
                  push_text($urandom_range(0, 5));
               end
            end
            case ($urandom_range(0, 2))
               0: begin
                  pending[pending.size() - 1].last = 1'b1;
                  n_buffers++;
               end
               1: push_crlf(1'b1);
               default: begin
                  push_crlf(1'b0);
                  push_text($urandom_range(0, 4));
                  push_req(noise_byte(), 1'b1);
               end
            endcase
         end else begin
            repeat ($urandom_range(0, 7)) push_req(noise_byte(), 1'b0);
            push_req(noise_byte(), 1'b1);
         end
         if (first_idx == 27 || $urandom_range(0, 39) == 0) pending[first_idx].hold = 1'b1;
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (pending.size() != 0 || req_tvalid) @(posedge clock);
      while (replies_expected.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Sent %0d request bytes in %0d buffers; checked %0d results", n_bytes,
               n_buffers, n_checked);
      $display("complete %0d, short %0d, bad separator %0d, truncated %0d,",
               n_status[0], n_status[1], n_status[2], n_status[3]);
      $display("multi-line %0d, known %0d", n_multi, n_known);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
